// ===== hdl/fbc_pkg.sv =====
// Package for the 16-bit Feistel block cipher: widths, register indexes,
// substitution boxes and the small key-index helpers.
// No dependencies.
`default_nettype none

package fbc_pkg;

  localparam int unsigned MAX_KEYS_DEF = 4;
  localparam int unsigned HALF_W       = 8;
  localparam int unsigned KEY_W        = 8;
  localparam int unsigned KCNT_W       = 3;
  localparam int unsigned RCNT_W       = 8;
  localparam int unsigned CFG_ADDR_W   = 3;
  localparam int unsigned CFG_DATA_W   = 8;
  localparam int unsigned DATA_W       = 2 * HALF_W;

  // register indexes of the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_KEY0  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KCNT  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_RCNT  = 3'd5;

  localparam logic CMD_ENC = 1'b0;
  localparam logic CMD_DEC = 1'b1;

  localparam logic [KCNT_W-1:0] KCNT_RST = 3'd4;
  localparam logic [RCNT_W-1:0] RCNT_RST = 8'd8;

  // S1(v) = (3^v mod 17 + 2) mod 16
  function automatic logic [3:0] sbox_lo(input logic [3:0] v);
    logic [3:0] s;
    case (v)
      4'd0:    s = 4'd3;
      4'd1:    s = 4'd5;
      4'd2:    s = 4'd11;
      4'd3:    s = 4'd12;
      4'd4:    s = 4'd15;
      4'd5:    s = 4'd7;
      4'd6:    s = 4'd1;
      4'd7:    s = 4'd13;
      4'd8:    s = 4'd2;
      4'd9:    s = 4'd0;
      4'd10:   s = 4'd10;
      4'd11:   s = 4'd9;
      4'd12:   s = 4'd6;
      4'd13:   s = 4'd14;
      4'd14:   s = 4'd4;
      default: s = 4'd8;
    endcase
    return s;
  endfunction

  // S2(v) = (5^v mod 17 + 7) mod 16
  function automatic logic [3:0] sbox_hi(input logic [3:0] v);
    logic [3:0] s;
    case (v)
      4'd0:    s = 4'd8;
      4'd1:    s = 4'd12;
      4'd2:    s = 4'd15;
      4'd3:    s = 4'd13;
      4'd4:    s = 4'd4;
      4'd5:    s = 4'd5;
      4'd6:    s = 4'd9;
      4'd7:    s = 4'd1;
      4'd8:    s = 4'd7;
      4'd9:    s = 4'd3;
      4'd10:   s = 4'd0;
      4'd11:   s = 4'd2;
      4'd12:   s = 4'd11;
      4'd13:   s = 4'd10;
      4'd14:   s = 4'd6;
      default: s = 4'd14;
    endcase
    return s;
  endfunction

  // Round function: substitute both nibbles, rotate left by 3.
  function automatic logic [HALF_W-1:0] round_f(input logic [HALF_W-1:0] v);
    logic [HALF_W-1:0] s;
    s = {sbox_hi(v[7:4]), sbox_lo(v[3:0])};
    return {s[4:0], s[7:5]};
  endfunction

  // v mod (last + 1) for a key count of 1 to 4. Base-4 digit sum for mod 3.
  function automatic logic [1:0] key_mod(input logic [RCNT_W-1:0] v,
                                         input logic [1:0]        last);
    logic [3:0] s;
    logic [2:0] t;
    logic [1:0] m3;
    logic [1:0] res;
    s  = {2'b00, v[1:0]} + {2'b00, v[3:2]} + {2'b00, v[5:4]} + {2'b00, v[7:6]};
    t  = {1'b0, s[1:0]} + {1'b0, s[3:2]};
    if (t >= 3'd3) t = t - 3'd3;
    m3 = (t == 3'd3) ? 2'd0 : t[1:0];
    case (last)
      2'd0:    res = 2'd0;
      2'd1:    res = {1'b0, v[0]};
      2'd2:    res = m3;
      default: res = v[1:0];
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/feistel_block_cipher_16bit_top.sv =====
// Top level of the 16-bit Feistel block cipher with 8-bit round keys.
// Depends on fbc_pkg.
//
// Usage:
//  - Input stream (in_*): one word is one block. in_tdata carries the left
//    byte in bits 7:0 and the right byte in bits 15:8; in_tuser is the
//    command (0 encrypt, 1 decrypt).
//  - Output stream (out_*): one word per block, left byte in bits 7:0,
//    right byte in bits 15:8.
//  - Config port: cfg_we writes cfg_wdata into register cfg_addr
//    (0..3 round keys, 4 key count, 5 round count); other indexes drop.
//    Write only while no block is in flight.
//  - One shared round unit runs one Feistel round per cycle. The next block
//    is taken in the cycle the result moves out to the output register, so
//    the round unit takes a new block only once the last one has left it.
//  - The output register parts the two sides: a finished result may wait
//    for out_tready while the next block is accepted and computed. A block
//    that finishes while the output is still full holds in the round unit,
//    and in_tready stays low until it moves on.
//  - Reset (rst_n low, synchronous) empties both stages and restores the
//    registers: keys 0, key count 4, round count 8.
`default_nettype none

module feistel_block_cipher_16bit_top #(
  parameter int unsigned MAX_KEYS = fbc_pkg::MAX_KEYS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [fbc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [fbc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [fbc_pkg::DATA_W-1:0]      in_tdata,   // left_in, right_in
  input  wire logic                            in_tuser,   // cmd
  // output stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [fbc_pkg::DATA_W-1:0]           out_tdata   // left_out, right_out
);
  import fbc_pkg::*;

  localparam int unsigned KIDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  // configuration registers
  logic [KEY_W-1:0]  key_r [MAX_KEYS];
  logic [KCNT_W-1:0] kcnt_r;
  logic [RCNT_W-1:0] rcnt_r;

  // round unit state
  logic              busy_r, busy_nxt;
  logic              dec_r, dec_nxt;
  logic [HALF_W-1:0] l_r, l_nxt;
  logic [HALF_W-1:0] r_r, r_nxt;
  logic [RCNT_W-1:0] rem_r, rem_nxt;
  logic [KIDX_W-1:0] kidx_r, kidx_nxt;

  // output register
  logic              ovld_r, ovld_nxt;
  logic [DATA_W-1:0] odata_r, odata_nxt;

  logic              in_fire, out_free, done, rnd;
  logic [KIDX_W-1:0] last_idx, dec_start;
  logic [HALF_W-1:0] f_in, f_out;
  logic [KEY_W-1:0]  cur_key;

  // Highest key index in use: key count clamped to 1..MAX_KEYS, minus one.
  always_comb begin
    if (kcnt_r == '0) begin
      last_idx = '0;
    end else if ({{(32-KCNT_W){1'b0}}, kcnt_r} > MAX_KEYS) begin
      last_idx = KIDX_W'(MAX_KEYS - 1);
    end else begin
      last_idx = KIDX_W'(kcnt_r - 3'd1);
    end
  end

  // Decryption starts at key (round_count - 1) mod n and walks down.
  assign dec_start = KIDX_W'(key_mod(rcnt_r - 8'd1, 2'(last_idx)));

  assign out_free  = !ovld_r || out_tready;
  assign done      = busy_r && (rem_r == '0);
  assign rnd       = busy_r && (rem_r != '0);
  assign in_tready = !busy_r || (done && out_free);
  assign in_fire   = in_tvalid && in_tready;

  // shared round unit: encrypt feeds R, decrypt feeds L
  assign cur_key = key_r[kidx_r];
  assign f_in    = (dec_r == CMD_DEC) ? l_r : r_r;
  assign f_out   = round_f(f_in ^ cur_key);

  always_comb begin
    busy_nxt  = busy_r;
    dec_nxt   = dec_r;
    l_nxt     = l_r;
    r_nxt     = r_r;
    rem_nxt   = rem_r;
    kidx_nxt  = kidx_r;
    ovld_nxt  = ovld_r;
    odata_nxt = odata_r;

    // drain the output register
    if (out_tready) begin
      ovld_nxt = 1'b0;
    end
    // hand a finished block to the output register
    if (done && out_free) begin
      busy_nxt  = 1'b0;
      ovld_nxt  = 1'b1;
      odata_nxt = {r_r, l_r};
    end

    if (in_fire) begin
      busy_nxt = 1'b1;
      dec_nxt  = in_tuser;
      l_nxt    = in_tdata[HALF_W-1:0];
      r_nxt    = in_tdata[DATA_W-1:HALF_W];
      rem_nxt  = rcnt_r;
      kidx_nxt = (in_tuser == CMD_DEC) ? dec_start : '0;
    end else if (rnd) begin
      rem_nxt = rem_r - 8'd1;
      if (dec_r == CMD_DEC) begin
        r_nxt    = l_r;
        l_nxt    = f_out ^ r_r;
        kidx_nxt = (kidx_r == '0) ? last_idx : kidx_r - 1'b1;
      end else begin
        l_nxt    = r_r;
        r_nxt    = f_out ^ l_r;
        kidx_nxt = (kidx_r == last_idx) ? '0 : kidx_r + 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    dec_r   <= dec_nxt;
    l_r     <= l_nxt;
    r_r     <= r_nxt;
    rem_r   <= rem_nxt;
    kidx_r  <= kidx_nxt;
    odata_r <= odata_nxt;
  end

  // configuration registers; keys above MAX_KEYS are never used, drop them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_KEYS; i++) begin
        key_r[i] <= '0;
      end
      kcnt_r <= KCNT_RST;
      rcnt_r <= RCNT_RST;
    end else if (cfg_we) begin
      if ({{(32-CFG_ADDR_W){1'b0}}, cfg_addr} < MAX_KEYS) begin
        key_r[cfg_addr[KIDX_W-1:0]] <= cfg_wdata;
      end else if (cfg_addr == REG_KCNT) begin
        kcnt_r <= cfg_wdata[KCNT_W-1:0];
      end else if (cfg_addr == REG_RCNT) begin
        rcnt_r <= cfg_wdata;
      end
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;

endmodule

`default_nettype wire
